@@ sv/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros used by the pps_checker module
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked only out of reset
`define PPS_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pps assertion failed");

// Next-cycle implication, checked only out of reset
`define PPS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pps assertion failed");

`endif

@@ sv/pps_pkg.sv @@
// ----------------------------------------------------------------------------
// pps_pkg
// Shared constants, widths and controller/datapath handshake types for the
// preemptive priority scheduler.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package pps_pkg;

    // Table depth
    localparam int unsigned MAX_PROCESSES = 16;

    // Field widths
    localparam int unsigned ARR_W      = 12;
    localparam int unsigned BURST_W    = 12;
    localparam int unsigned PRI_W      = 8;
    localparam int unsigned PNUM_W     = 5;
    localparam int unsigned OUT_TIME_W = 17;
    localparam int unsigned SUM_W      = 21;

    // Derived widths
    localparam int unsigned IDX_W  = $clog2(MAX_PROCESSES);
    localparam int unsigned CNT_W  = $clog2(MAX_PROCESSES + 1);
    localparam int unsigned TIME_W = $clog2((1 << ARR_W) * (MAX_PROCESSES + 1));

    // Commands from controller to datapath
    typedef struct packed {
        logic load;       // write the incoming word into the tables
        logic idx_clr;    // rewind the entry pointer
        logic idx_inc;    // advance the entry pointer
        logic min_step;   // fold one entry into the start-time search
        logic scan_step;  // fold one entry into the tick selection
        logic apply;      // run the selected process for one tick
        logic jump;       // skip idle ticks to the next arrival
        logic emit;       // load one result into the output register
        logic clr_run;    // drop the finished set
    } pps_cmd_t;

    // Status from datapath to controller
    typedef struct packed {
        logic idx_last;   // pointer sits on the last stored entry
        logic found;      // a ready process was selected by the scan
        logic pend_any;   // an unfinished process has not yet arrived
        logic out_free;   // output register can take a word
    } pps_sts_t;

endpackage

`default_nettype wire

@@ sv/pps_in_if.sv @@
// ----------------------------------------------------------------------------
// pps_in_if
// Load channel: one process record per word.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface pps_in_if;
    logic                         valid;
    logic                         ready;
    logic [pps_pkg::ARR_W-1:0]    arrival_time;
    logic [pps_pkg::BURST_W-1:0]  burst_time;
    logic [pps_pkg::PRI_W-1:0]    priority_level;
    logic                         last_process;

    modport source (
        output valid, arrival_time, burst_time, priority_level, last_process,
        input  ready
    );
    modport sink (
        input  valid, arrival_time, burst_time, priority_level, last_process,
        output ready
    );
endinterface

`default_nettype wire

@@ sv/pps_out_if.sv @@
// ----------------------------------------------------------------------------
// pps_out_if
// Result channel: one per-process report per word.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface pps_out_if;
    logic                            valid;
    logic                            ready;
    logic [pps_pkg::PNUM_W-1:0]      process_number;
    logic [pps_pkg::OUT_TIME_W-1:0]  completion_time;
    logic [pps_pkg::OUT_TIME_W-1:0]  turnaround_time;
    logic [pps_pkg::OUT_TIME_W-1:0]  waiting_time;
    logic [pps_pkg::SUM_W-1:0]       total_turnaround;
    logic [pps_pkg::SUM_W-1:0]       total_waiting;
    logic                            last_result;

    modport source (
        output valid, process_number, completion_time, turnaround_time, waiting_time,
               total_turnaround, total_waiting, last_result,
        input  ready
    );
    modport sink (
        input  valid, process_number, completion_time, turnaround_time, waiting_time,
               total_turnaround, total_waiting, last_result,
        output ready
    );
endinterface

`default_nettype wire

@@ sv/pps_ctrl.sv @@
// ----------------------------------------------------------------------------
// pps_ctrl
// Sequencer: load, start-time search, per-tick scan and decision, report.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pps_ctrl (
    input  wire                    clk,
    input  wire                    rst_n,
    input  wire                    in_valid,
    input  wire                    in_last,
    output logic                   in_ready,
    output pps_pkg::pps_cmd_t      cmd,
    input  wire pps_pkg::pps_sts_t sts
);

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_MIN_SCAN,
        ST_SCAN,
        ST_DECIDE,
        ST_REPORT
    } state_t;

    state_t state_reg;
    state_t state_next;

    // Hold state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_LOAD;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Decode commands and next state
    always_comb
    begin
        cmd        = '0;
        in_ready   = 1'b0;
        state_next = state_reg;
        case (state_reg)
            ST_LOAD:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load = 1'b1;
                    if (in_last)
                    begin
                        cmd.idx_clr = 1'b1;
                        state_next  = ST_MIN_SCAN;
                    end
                end
            end
            ST_MIN_SCAN:
            begin
                cmd.min_step = 1'b1;
                if (sts.idx_last)
                begin
                    cmd.idx_clr = 1'b1;
                    state_next  = ST_SCAN;
                end
                else
                begin
                    cmd.idx_inc = 1'b1;
                end
            end
            ST_SCAN:
            begin
                cmd.scan_step = 1'b1;
                if (sts.idx_last)
                begin
                    cmd.idx_clr = 1'b1;
                    state_next  = ST_DECIDE;
                end
                else
                begin
                    cmd.idx_inc = 1'b1;
                end
            end
            ST_DECIDE:
            begin
                if (sts.found)
                begin
                    cmd.apply  = 1'b1;
                    state_next = ST_SCAN;
                end
                else if (sts.pend_any)
                begin
                    cmd.jump   = 1'b1;
                    state_next = ST_SCAN;
                end
                else
                begin
                    state_next = ST_REPORT;
                end
            end
            ST_REPORT:
            begin
                if (sts.out_free)
                begin
                    cmd.emit = 1'b1;
                    if (sts.idx_last)
                    begin
                        cmd.clr_run = 1'b1;
                        state_next  = ST_LOAD;
                    end
                    else
                    begin
                        cmd.idx_inc = 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

endmodule

`default_nettype wire

@@ sv/pps_dp.sv @@
// ----------------------------------------------------------------------------
// pps_dp
// Datapath: process tables, tick clock, selection scan and result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pps_dp (
    input  wire                                 clk,
    input  wire                                 rst_n,
    input  wire pps_pkg::pps_cmd_t              cmd,
    output pps_pkg::pps_sts_t                   sts,
    input  wire [pps_pkg::ARR_W-1:0]            arrival_time,
    input  wire [pps_pkg::BURST_W-1:0]          burst_time,
    input  wire [pps_pkg::PRI_W-1:0]            priority_level,
    output logic                                out_valid,
    input  wire                                 out_ready,
    output logic [pps_pkg::PNUM_W-1:0]          process_number,
    output logic [pps_pkg::OUT_TIME_W-1:0]      completion_time,
    output logic [pps_pkg::OUT_TIME_W-1:0]      turnaround_time,
    output logic [pps_pkg::OUT_TIME_W-1:0]      waiting_time,
    output logic [pps_pkg::SUM_W-1:0]           total_turnaround,
    output logic [pps_pkg::SUM_W-1:0]           total_waiting,
    output logic                                last_result
);

    localparam int unsigned N      = pps_pkg::MAX_PROCESSES;
    localparam int unsigned IDX_W  = pps_pkg::IDX_W;
    localparam int unsigned CNT_W  = pps_pkg::CNT_W;
    localparam int unsigned TIME_W = pps_pkg::TIME_W;
    localparam int unsigned ARR_W  = pps_pkg::ARR_W;
    localparam int unsigned BUR_W  = pps_pkg::BURST_W;
    localparam int unsigned PRI_W  = pps_pkg::PRI_W;
    localparam int unsigned OT_W   = pps_pkg::OUT_TIME_W;
    localparam int unsigned SUM_W  = pps_pkg::SUM_W;
    localparam int unsigned PN_W   = pps_pkg::PNUM_W;

    // Process tables
    logic [ARR_W-1:0]  arr_mem  [N];
    logic [BUR_W-1:0]  bur_mem  [N];
    logic [BUR_W-1:0]  rem_mem  [N];
    logic [PRI_W-1:0]  pri_mem  [N];
    logic [TIME_W-1:0] comp_mem [N];
    logic [N-1:0]      done_reg;

    // Run control
    logic [CNT_W-1:0]  count_reg;
    logic [IDX_W-1:0]  idx_reg;
    logic [TIME_W-1:0] t_reg;

    // Scan result
    logic              found_reg;
    logic              found_next;
    logic [IDX_W-1:0]  best_idx_reg;
    logic [IDX_W-1:0]  best_idx_next;
    logic [PRI_W-1:0]  best_pri_reg;
    logic [PRI_W-1:0]  best_pri_next;
    logic [ARR_W-1:0]  best_arr_reg;
    logic [ARR_W-1:0]  best_arr_next;
    logic [BUR_W-1:0]  best_rem_reg;
    logic [BUR_W-1:0]  best_rem_next;
    logic              pend_reg;
    logic              pend_next;
    logic [ARR_W-1:0]  pend_min_reg;
    logic [ARR_W-1:0]  pend_min_next;

    // Output register
    logic              out_valid_reg;
    logic [PN_W-1:0]   pnum_reg;
    logic [OT_W-1:0]   comp_out_reg;
    logic [OT_W-1:0]   tat_out_reg;
    logic [OT_W-1:0]   wt_out_reg;
    logic [SUM_W-1:0]  sum_tat_reg;
    logic [SUM_W-1:0]  sum_tat_next;
    logic [SUM_W-1:0]  sum_wt_reg;
    logic [SUM_W-1:0]  sum_wt_next;
    logic              last_out_reg;

    // Entry under the pointer
    logic [ARR_W-1:0]  arr_k;
    logic [PRI_W-1:0]  pri_k;
    logic              done_k;
    logic              ready_k;
    logic              better_k;
    logic              first_k;
    logic              idx_last;
    logic              table_full;
    logic [IDX_W-1:0]  wr_idx;
    logic [TIME_W-1:0] tat_full;
    logic [TIME_W-1:0] wt_full;

    assign arr_k      = arr_mem[idx_reg];
    assign pri_k      = pri_mem[idx_reg];
    assign done_k     = done_reg[idx_reg];
    assign first_k    = (idx_reg == '0);
    assign idx_last   = ((CNT_W'(idx_reg) + CNT_W'(1)) == count_reg);
    assign table_full = (count_reg == CNT_W'(N));
    assign wr_idx     = count_reg[IDX_W-1:0];
    assign ready_k    = !done_k && (TIME_W'(arr_k) <= t_reg);

    // Earlier arrival breaks a priority tie; scan order breaks the rest
    assign better_k = first_k || !found_reg || (pri_k < best_pri_reg) ||
                      ((pri_k == best_pri_reg) && (arr_k < best_arr_reg));

    // Fold one entry into the tick selection
    always_comb
    begin
        found_next    = first_k ? 1'b0 : found_reg;
        pend_next     = first_k ? 1'b0 : pend_reg;
        best_idx_next = best_idx_reg;
        best_pri_next = best_pri_reg;
        best_arr_next = best_arr_reg;
        best_rem_next = best_rem_reg;
        pend_min_next = pend_min_reg;
        if (ready_k && better_k)
        begin
            found_next    = 1'b1;
            best_idx_next = idx_reg;
            best_pri_next = pri_k;
            best_arr_next = arr_k;
            best_rem_next = rem_mem[idx_reg];
        end
        if (!done_k && !ready_k && (!pend_next || (arr_k < pend_min_reg)))
        begin
            pend_next     = 1'b1;
            pend_min_next = arr_k;
        end
    end

    // Result arithmetic for the entry under the pointer
    assign tat_full     = comp_mem[idx_reg] - TIME_W'(arr_k);
    assign wt_full      = tat_full - TIME_W'(bur_mem[idx_reg]);
    assign sum_tat_next = (first_k ? '0 : sum_tat_reg) + SUM_W'(tat_full);
    assign sum_wt_next  = (first_k ? '0 : sum_wt_reg) + SUM_W'(wt_full);

    // Write tables on load and on tick
    always_ff @(posedge clk)
    begin
        if (cmd.load && !table_full)
        begin
            arr_mem[wr_idx]  <= arrival_time;
            bur_mem[wr_idx]  <= burst_time;
            rem_mem[wr_idx]  <= burst_time;
            pri_mem[wr_idx]  <= priority_level;
            comp_mem[wr_idx] <= TIME_W'(arrival_time);
        end
        if (cmd.apply)
        begin
            rem_mem[best_idx_reg] <= best_rem_reg - BUR_W'(1);
            if (best_rem_reg == BUR_W'(1))
            begin
                comp_mem[best_idx_reg] <= t_reg + TIME_W'(1);
            end
        end
    end

    // Hold scan payload and the result word
    always_ff @(posedge clk)
    begin
        if (cmd.scan_step)
        begin
            best_idx_reg <= best_idx_next;
            best_pri_reg <= best_pri_next;
            best_arr_reg <= best_arr_next;
            best_rem_reg <= best_rem_next;
            pend_min_reg <= pend_min_next;
        end
        if (cmd.emit)
        begin
            pnum_reg     <= PN_W'(CNT_W'(idx_reg) + CNT_W'(1));
            comp_out_reg <= OT_W'(comp_mem[idx_reg]);
            tat_out_reg  <= OT_W'(tat_full);
            wt_out_reg   <= OT_W'(wt_full);
            sum_tat_reg  <= sum_tat_next;
            sum_wt_reg   <= sum_wt_next;
            last_out_reg <= idx_last;
        end
    end

    // Advance control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            done_reg      <= '0;
            idx_reg       <= '0;
            t_reg         <= '0;
            found_reg     <= 1'b0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.load && !table_full)
            begin
                count_reg        <= count_reg + CNT_W'(1);
                done_reg[wr_idx] <= (burst_time == '0);
            end
            if (cmd.idx_clr || cmd.clr_run)
            begin
                idx_reg <= '0;
            end
            else if (cmd.idx_inc)
            begin
                idx_reg <= idx_reg + IDX_W'(1);
            end
            // Start time is the earliest arrival of the whole set
            if (cmd.min_step && (first_k || (TIME_W'(arr_k) < t_reg)))
            begin
                t_reg <= TIME_W'(arr_k);
            end
            if (cmd.scan_step)
            begin
                found_reg <= found_next;
                pend_reg  <= pend_next;
            end
            if (cmd.apply)
            begin
                t_reg <= t_reg + TIME_W'(1);
                if (best_rem_reg == BUR_W'(1))
                begin
                    done_reg[best_idx_reg] <= 1'b1;
                end
            end
            if (cmd.jump)
            begin
                t_reg <= TIME_W'(pend_min_reg);
            end
            if (cmd.clr_run)
            begin
                count_reg <= '0;
                done_reg  <= '0;
                t_reg     <= '0;
            end
            if (cmd.emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Status
    assign sts.idx_last = idx_last;
    assign sts.found    = found_reg;
    assign sts.pend_any = pend_reg;
    assign sts.out_free = !out_valid_reg || out_ready;

    // Drive result word
    assign out_valid        = out_valid_reg;
    assign process_number   = pnum_reg;
    assign completion_time  = comp_out_reg;
    assign turnaround_time  = tat_out_reg;
    assign waiting_time     = wt_out_reg;
    assign total_turnaround = sum_tat_reg;
    assign total_waiting    = sum_wt_reg;
    assign last_result      = last_out_reg;

endmodule

`default_nettype wire

@@ sv/preemptive_priority_scheduler.sv @@
// ----------------------------------------------------------------------------
// preemptive_priority_scheduler
// Unit-tick preemptive priority scheduler with per-process timing report.
// ----------------------------------------------------------------------------
// Records are loaded one word per cycle into a 16-entry table; extra loads
// are dropped. A word with last_process set starts the run and the load
// channel stays stalled until the last result word has been handed to the
// output register. The run first walks the stored entries to find the
// start time, then repeats a schedule step: a scan of the table, one entry
// per cycle, for the ready process with the lowest priority value, then a
// decision that runs it for one tick, skips idle time to the next arrival,
// or, once every process is finished, moves on to the report. The report
// gives one result word per cycle in load order when the sink keeps up.
// The table scan dominates the run time.
`timescale 1ns / 1ps
`default_nettype none

module preemptive_priority_scheduler (
    input  wire        clk,
    input  wire        rst_n,
    pps_in_if.sink     load,
    pps_out_if.source  result
);

    pps_pkg::pps_cmd_t cmd;
    pps_pkg::pps_sts_t sts;
    logic              in_ready;

    assign load.ready = in_ready;

    pps_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (load.valid),
        .in_last  (load.last_process),
        .in_ready (in_ready),
        .cmd      (cmd),
        .sts      (sts)
    );

    pps_dp u_dp (
        .clk              (clk),
        .rst_n            (rst_n),
        .cmd              (cmd),
        .sts              (sts),
        .arrival_time     (load.arrival_time),
        .burst_time       (load.burst_time),
        .priority_level   (load.priority_level),
        .out_valid        (result.valid),
        .out_ready        (result.ready),
        .process_number   (result.process_number),
        .completion_time  (result.completion_time),
        .turnaround_time  (result.turnaround_time),
        .waiting_time     (result.waiting_time),
        .total_turnaround (result.total_turnaround),
        .total_waiting    (result.total_waiting),
        .last_result      (result.last_result)
    );

endmodule

`default_nettype wire

@@ sv/pps_checker.sv @@
// ----------------------------------------------------------------------------
// pps_checker
// Port-level checks of the scheduler's load and result channels.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module pps_checker (
    input wire clk,
    input wire rst_n,
    input wire load_valid,
    input wire load_ready,
    input wire load_last,
    input wire result_valid,
    input wire result_ready,
    input wire result_last
);

    // A stalled result word stays offered
    `PPS_ASSERT_NEXT(a_result_hold, clk, rst_n, result_valid && !result_ready, result_valid)

    // The final load of a set closes the load channel for the run
    `PPS_ASSERT_NEXT(a_run_stalls_load, clk, rst_n, load_valid && load_ready && load_last, !load_ready)

    // Any other load keeps the channel open
    `PPS_ASSERT_NEXT(a_load_stays_open, clk, rst_n, load_valid && load_ready && !load_last, load_ready)

    // No loads while a report is still in progress
    `PPS_ASSERT_SAME(a_report_blocks_load, clk, rst_n, result_valid && !result_last, !load_ready)

endmodule

bind preemptive_priority_scheduler pps_checker u_pps_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .load_valid   (load.valid),
    .load_ready   (load.ready),
    .load_last    (load.last_process),
    .result_valid (result.valid),
    .result_ready (result.ready),
    .result_last  (result.last_result)
);

`default_nettype wire

@@ sim/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the preemptive priority scheduler. A directed set of
// process records covers field extremes, preemption, tie breaking, idle
// jumps, zero bursts and a full table. Random sets of mixed size follow. The
// load side and the result side both stall at random. Every report word is
// checked field by field against a tick-level schedule computed in the bench.
// ----------------------------------------------------------------------------

module tb;

    typedef struct {
        logic [pps_pkg::ARR_W-1:0]   arrival;
        logic [pps_pkg::BURST_W-1:0] burst;
        logic [pps_pkg::PRI_W-1:0]   prio;
        logic                        last;
    } proc_rec_t;

    typedef struct {
        logic [pps_pkg::PNUM_W-1:0]     pnum;
        logic [pps_pkg::OUT_TIME_W-1:0] done_at;
        logic [pps_pkg::OUT_TIME_W-1:0] turnaround;
        logic [pps_pkg::OUT_TIME_W-1:0] waiting;
        logic [pps_pkg::SUM_W-1:0]      sum_tat;
        logic [pps_pkg::SUM_W-1:0]      sum_wait;
        logic                           last;
    } report_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    pps_in_if  load_ch ();
    pps_out_if result_ch ();

    preemptive_priority_scheduler dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .load   (load_ch),
        .result (result_ch)
    );

    always #4 clk = ~clk;

    // Stimulus and expectations
    proc_rec_t pending_records[$];
    report_t   expected_reports[$];

    // Bench copy of the process table
    int tbl_arrival [pps_pkg::MAX_PROCESSES];
    int tbl_burst   [pps_pkg::MAX_PROCESSES];
    int tbl_left    [pps_pkg::MAX_PROCESSES];
    int tbl_prio    [pps_pkg::MAX_PROCESSES];
    bit tbl_done    [pps_pkg::MAX_PROCESSES];
    int tbl_done_at [pps_pkg::MAX_PROCESSES];
    int stored_count = 0;

    // Run bookkeeping
    int     error_count = 0;
    int     words_loaded = 0;
    int     sets_run = 0;
    int     reports_checked = 0;
    int     dropped_loads = 0;
    int     zero_bursts = 0;
    longint cycle_budget = 0;
    longint cycle_limit = 64'd2000000000;
    longint cycle_count = 0;

    // Planning state for the stimulus budget
    int plan_stored = 0;
    int plan_burst = 0;

    bit in_taken = 1'b0;
    int send_gap = 0;
    int calm_src = 0;
    int stall_left = 0;
    int calm_snk = 0;

    task automatic report_mismatch(input string what, input longint got, input longint want,
                                   input int pnum);
        if (error_count < 50)
            $display("[%0t] MISMATCH %s: process %0d got %0d expected %0d",
                     $time, what, pnum, got, want);
        error_count++;
    endtask

    // Mostly short gaps, a few long ones
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 0;
        else if (r < 85)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 10);
        else
            return $urandom_range(20, 60);
    endfunction

    // Queue one record and extend the cycle budget
    task automatic queue_record(input int a, input int b, input int p, input bit l);
        proc_rec_t rec;
        int n;
        rec.arrival = a[pps_pkg::ARR_W-1:0];
        rec.burst   = b[pps_pkg::BURST_W-1:0];
        rec.prio    = p[pps_pkg::PRI_W-1:0];
        rec.last    = l;
        pending_records.push_back(rec);
        cycle_budget += 70;
        if (plan_stored < pps_pkg::MAX_PROCESSES)
        begin
            plan_stored++;
            plan_burst += b;
        end
        if (l)
        begin
            n = plan_stored;
            cycle_budget += n + longint'(n + 1) * (plan_burst + n + 2) + n * 70;
            plan_stored = 0;
            plan_burst = 0;
        end
    endtask

    // Run the stored set tick by tick and queue one report per process
    function automatic void schedule_and_report();
        int  t;
        int  left;
        int  best;
        int  nxt;
        int  tat;
        int  wt;
        int  sum_tat;
        int  sum_wt;
        bit  found;
        bit  any;
        report_t rep;
        t = tbl_arrival[0];
        left = 0;
        for (int k = 0; k < stored_count; k++)
        begin
            if (tbl_arrival[k] < t)
                t = tbl_arrival[k];
            if (!tbl_done[k])
                left++;
        end
        while (left > 0)
        begin
            found = 1'b0;
            best = 0;
            for (int k = 0; k < stored_count; k++)
            begin
                if (!tbl_done[k] && tbl_arrival[k] <= t)
                begin
                    if (!found || tbl_prio[k] < tbl_prio[best] ||
                        (tbl_prio[k] == tbl_prio[best] && tbl_arrival[k] < tbl_arrival[best]))
                    begin
                        best = k;
                        found = 1'b1;
                    end
                end
            end
            if (!found)
            begin
                // skip idle ticks to the earliest pending arrival
                any = 1'b0;
                nxt = 0;
                for (int k = 0; k < stored_count; k++)
                begin
                    if (!tbl_done[k] && (!any || tbl_arrival[k] < nxt))
                    begin
                        nxt = tbl_arrival[k];
                        any = 1'b1;
                    end
                end
                t = nxt;
            end
            else
            begin
                tbl_left[best]--;
                t++;
                if (tbl_left[best] == 0)
                begin
                    tbl_done[best] = 1'b1;
                    tbl_done_at[best] = t;
                    left--;
                end
            end
        end
        sum_tat = 0;
        sum_wt = 0;
        for (int k = 0; k < stored_count; k++)
        begin
            tat = tbl_done_at[k] - tbl_arrival[k];
            wt = tat - tbl_burst[k];
            sum_tat += tat;
            sum_wt += wt;
            rep.pnum       = pps_pkg::PNUM_W'(k + 1);
            rep.done_at    = pps_pkg::OUT_TIME_W'(tbl_done_at[k]);
            rep.turnaround = pps_pkg::OUT_TIME_W'(tat);
            rep.waiting    = pps_pkg::OUT_TIME_W'(wt);
            rep.sum_tat    = pps_pkg::SUM_W'(sum_tat);
            rep.sum_wait   = pps_pkg::SUM_W'(sum_wt);
            rep.last       = (k + 1 == stored_count);
            expected_reports.push_back(rep);
        end
        // empty the table for the next set
        for (int k = 0; k < pps_pkg::MAX_PROCESSES; k++)
            tbl_done[k] = 1'b0;
        stored_count = 0;
        sets_run++;
    endfunction

    // Store one accepted record; a last mark starts the run
    function automatic void take_record(proc_rec_t r);
        if (stored_count < pps_pkg::MAX_PROCESSES)
        begin
            tbl_arrival[stored_count] = int'(r.arrival);
            tbl_burst[stored_count]   = int'(r.burst);
            tbl_left[stored_count]    = int'(r.burst);
            tbl_prio[stored_count]    = int'(r.prio);
            tbl_done[stored_count]    = (r.burst == 0);
            tbl_done_at[stored_count] = int'(r.arrival);
            stored_count++;
            if (r.burst == 0)
                zero_bursts++;
        end
        else
            dropped_loads++;
        if (r.last && stored_count > 0)
            schedule_and_report();
    endfunction

    // Load driver: present the next word once the previous one is taken
    always @(negedge clk)
    begin
        proc_rec_t rec;
        if (rst_n && (!load_ch.valid || in_taken))
        begin
            if (send_gap > 0)
            begin
                send_gap--;
                load_ch.valid <= 1'b0;
            end
            else if (pending_records.size() > 0)
            begin
                rec = pending_records.pop_front();
                load_ch.arrival_time   <= rec.arrival;
                load_ch.burst_time     <= rec.burst;
                load_ch.priority_level <= rec.prio;
                load_ch.last_process   <= rec.last;
                load_ch.valid          <= 1'b1;
                if (calm_src > 0)
                begin
                    calm_src--;
                    send_gap = 0;
                end
                else
                begin
                    send_gap = pick_gap();
                    if ($urandom_range(0, 19) == 0)
                        calm_src = $urandom_range(10, 30);
                end
            end
            else
                load_ch.valid <= 1'b0;
        end
    end

    // Result sink: stall ready at random, with stretches of no stall
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (calm_snk > 0)
                calm_snk--;
            if (stall_left > 0)
            begin
                stall_left--;
                result_ch.ready <= 1'b0;
            end
            else
            begin
                result_ch.ready <= 1'b1;
                if (calm_snk == 0)
                begin
                    if ($urandom_range(0, 99) == 0)
                        calm_snk = $urandom_range(200, 600);
                    else if ($urandom_range(0, 3) == 0)
                        stall_left = pick_gap();
                end
            end
        end
    end

    // Monitor: feed accepted loads to the model, check report words
    always @(posedge clk)
    begin
        proc_rec_t rec;
        report_t   got;
        report_t   want;
        if (rst_n)
        begin
            in_taken <= load_ch.valid && load_ch.ready;
            if (load_ch.valid && load_ch.ready)
            begin
                rec.arrival = load_ch.arrival_time;
                rec.burst   = load_ch.burst_time;
                rec.prio    = load_ch.priority_level;
                rec.last    = load_ch.last_process;
                words_loaded++;
                take_record(rec);
            end
            if (result_ch.valid && result_ch.ready)
            begin
                got.pnum       = result_ch.process_number;
                got.done_at    = result_ch.completion_time;
                got.turnaround = result_ch.turnaround_time;
                got.waiting    = result_ch.waiting_time;
                got.sum_tat    = result_ch.total_turnaround;
                got.sum_wait   = result_ch.total_waiting;
                got.last       = result_ch.last_result;
                if (expected_reports.size() == 0)
                    report_mismatch("unexpected report word", got.pnum, 0, got.pnum);
                else
                begin
                    want = expected_reports.pop_front();
                    reports_checked++;
                    if (got.pnum !== want.pnum)
                        report_mismatch("process_number", got.pnum, want.pnum, want.pnum);
                    if (got.done_at !== want.done_at)
                        report_mismatch("completion_time", got.done_at, want.done_at,
                                        want.pnum);
                    if (got.turnaround !== want.turnaround)
                        report_mismatch("turnaround_time", got.turnaround, want.turnaround,
                                        want.pnum);
                    if (got.waiting !== want.waiting)
                        report_mismatch("waiting_time", got.waiting, want.waiting, want.pnum);
                    if (got.sum_tat !== want.sum_tat)
                        report_mismatch("total_turnaround", got.sum_tat, want.sum_tat,
                                        want.pnum);
                    if (got.sum_wait !== want.sum_wait)
                        report_mismatch("total_waiting", got.sum_wait, want.sum_wait,
                                        want.pnum);
                    if (got.last !== want.last)
                        report_mismatch("last_result", got.last, want.last, want.pnum);
                end
            end
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > cycle_limit)
        begin
            $display("timeout after %0d cycles, %0d reports still due",
                     cycle_count, expected_reports.size());
            $display("simulation failed");
            $finish;
        end
    end

    initial
    begin
        int r;
        int n;
        int a;
        int b;
        int p;
        int random_items;
        bit spread;
        bit narrow;
        bit big_used;

        load_ch.valid          = 1'b0;
        load_ch.arrival_time   = '0;
        load_ch.burst_time     = '0;
        load_ch.priority_level = '0;
        load_ch.last_process   = 1'b0;
        result_ch.ready        = 1'b0;

        // Extremes: idle jump to the top arrival with the longest burst
        queue_record(4095, 4095, 255, 1'b0);
        queue_record(0, 1, 0, 1'b1);

        // Preemption, priority ties broken by arrival, then by load order
        queue_record(0, 4, 3, 1'b0);
        queue_record(1, 2, 3, 1'b0);
        queue_record(2, 2, 1, 1'b0);
        queue_record(2, 3, 1, 1'b1);

        // Idle time between arrivals and a zero burst
        queue_record(10, 3, 5, 1'b0);
        queue_record(50, 2, 0, 1'b0);
        queue_record(20, 0, 7, 1'b0);
        queue_record(100, 1, 9, 1'b1);

        // Full table; the extra word carries the last mark and is dropped
        for (int i = 0; i < pps_pkg::MAX_PROCESSES; i++)
            queue_record(i * 3, 1 + (i % 4), 15 - i, 1'b0);
        queue_record(1, 1, 0, 1'b1);

        // Random sets, mostly small bursts with an occasional long one
        random_items = 0;
        while (random_items < 125)
        begin
            r = $urandom_range(0, 99);
            if (r < 65)
                n = $urandom_range(1, 6);
            else if (r < 90)
                n = $urandom_range(7, 15);
            else
                n = $urandom_range(16, 19);
            spread = ($urandom_range(0, 3) == 0);
            narrow = ($urandom_range(0, 1) == 1);
            big_used = 1'b0;
            for (int i = 0; i < n; i++)
            begin
                a = spread ? $urandom_range(0, 4095) : $urandom_range(0, 30);
                r = $urandom_range(0, 99);
                if (r < 4)
                    b = 0;
                else if (r < 8 && !big_used)
                begin
                    b = $urandom_range(256, 4095);
                    big_used = 1'b1;
                end
                else
                    b = $urandom_range(1, 12);
                p = narrow ? $urandom_range(0, 3) : $urandom_range(0, 255);
                queue_record(a, b, p, i == n - 1);
            end
            random_items += n;
        end

        cycle_limit = 4 * cycle_budget + 20000;

        // Hold reset, then release on a falling edge
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Drain: all words sent and every report received
        while (pending_records.size() > 0 || load_ch.valid || expected_reports.size() > 0)
            @(posedge clk);
        repeat (50) @(posedge clk);

        $display("loaded %0d words in %0d sets (%0d dropped, %0d zero bursts)",
                 words_loaded, sets_run, dropped_loads, zero_bursts);
        $display("checked %0d report words in %0d cycles, %0d mismatches",
                 reports_checked, cycle_count, error_count);
        if (error_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

@@ sim.f @@
+incdir+sv
sv/pps_pkg.sv
sv/pps_in_if.sv
sv/pps_out_if.sv
sv/pps_ctrl.sv
sv/pps_dp.sv
sv/preemptive_priority_scheduler.sv
sv/pps_checker.sv
sim/tb.sv
